[design/wmrc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wmrc_pkg
// Shared types, constants and the pass classifier for the word-match read
// classifier.
// ----------------------------------------------------------------------------
package wmrc_pkg;

    localparam int MAX_WINDOWS = 1024;
    localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
    localparam int FIELD_W     = 11;
    localparam int AMB_W       = 4;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int VOTE_W      = 6;
    localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int PROD_W      = CMP_W + 3;

    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_WINDOWS);
    localparam logic [VOTE_W-1:0] VOTE_MAX = VOTE_W'(63);

    localparam logic [AMB_W-1:0] MAX_AMB_RESET   = AMB_W'(0);
    localparam logic [CFG_W-1:0] MIN_WORDS_RESET = CFG_W'(10);
    localparam logic [CFG_W-1:0] SWITCH_RESET    = CFG_W'(200);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_AMBIGUITIES   = 2'd0,
        REG_MIN_WORDS         = 2'd1,
        REG_LONG_WORDS_SWITCH = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        TAG_FOREIGN   = 2'd0,
        TAG_UNCERTAIN = 2'd1,
        TAG_HUMAN     = 2'd2
    } tag_t;

    typedef struct packed {
        logic             new_read;
        logic             has_window;
        logic [AMB_W-1:0] ambiguity_count;
        logic             found;
        logic             end_of_pass;
    } req_t;

    typedef struct packed {
        logic [1:0]         pass_tag;
        logic [1:0]         read_tag;
        logic [FIELD_W-1:0] word_total;
        logic [FIELD_W-1:0] match_total;
        logic [FIELD_W-1:0] longest_run;
    } rsp_t;

    function automatic tag_t classify(
        input logic [CNT_W-1:0] longest,
        input logic [CNT_W-1:0] hit_count,
        input logic [CNT_W-1:0] words,
        input logic [CFG_W-1:0] min_words,
        input logic [CFG_W-1:0] long_switch
    );
        logic [PROD_W-1:0] w1;
        logic [PROD_W-1:0] w2;
        logic [PROD_W-1:0] w3;
        logic [PROD_W-1:0] w4;
        logic [PROD_W-1:0] m5;
        logic [PROD_W-1:0] l5;
        logic              relaxed;
        tag_t              tag;
        w1 = PROD_W'(words);
        w2 = PROD_W'(w1 << 1);
        w4 = PROD_W'(w1 << 2);
        w3 = w1 + w2;
        m5 = PROD_W'(hit_count) * PROD_W'(5);
        l5 = PROD_W'(longest) * PROD_W'(5);
        relaxed = w1 >= PROD_W'(long_switch);
        if (w1 < PROD_W'(min_words))
        begin
            tag = TAG_UNCERTAIN;
        end
        else if ((m5 < w1) && ((PROD_W'(longest) * PROD_W'(10)) < w1))
        begin
            tag = TAG_FOREIGN;
        end
        else if (relaxed && (m5 >= w3) && (l5 >= w1))
        begin
            tag = TAG_HUMAN;
        end
        else if (!relaxed && (m5 >= w4) && (l5 >= w2))
        begin
            tag = TAG_HUMAN;
        end
        else
        begin
            tag = TAG_UNCERTAIN;
        end
        return tag;
    endfunction

endpackage
`default_nettype wire

[design/word_match_read_classifier.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// word_match_read_classifier
// Counts qualifying windows, matches and the longest match run of a pass,
// classifies the pass at its end and keeps saturating per-read votes.
// A request is held in the input register; its result is then registered in
// the result register, and an output stall holds either stage in place.
// Throughput: one request per cycle unless stalled; limited by the pass counter update loop.
// Reset clears all counters, votes and valid flags and restores the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
module word_match_read_classifier
    import wmrc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire req_t                 in_req,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output rsp_t                      out_rsp
);

    logic [AMB_W-1:0]  max_amb_reg;
    logic [CFG_W-1:0]  min_words_reg;
    logic [CFG_W-1:0]  switch_reg;

    logic              s1_valid_reg, s1_valid_next;
    req_t              s1_req_reg, s1_req_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_rsp_reg, out_rsp_next;

    logic [CNT_W-1:0]  word_reg, word_next;
    logic [CNT_W-1:0]  match_reg, match_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  best_reg, best_next;
    logic [VOTE_W-1:0] human_reg, human_next;
    logic [VOTE_W-1:0] unc_reg, unc_next;
    logic [VOTE_W-1:0] foreign_reg, foreign_next;

    logic              advance;
    logic              counted;
    logic              hit;
    logic              emit;
    logic [CNT_W-1:0]  w_upd;
    logic [CNT_W-1:0]  m_upd;
    logic [CNT_W-1:0]  r_upd;
    logic [CNT_W-1:0]  b_upd;
    logic [CNT_W-1:0]  b_fin;
    tag_t              pass_tag;
    tag_t              read_tag;
    logic [VOTE_W-1:0] h_base;
    logic [VOTE_W-1:0] u_base;
    logic [VOTE_W-1:0] f_base;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    always_comb
    begin
        counted = s1_req_reg.ambiguity_count <= max_amb_reg;
        hit     = counted && s1_req_reg.found;
        w_upd   = (counted && (word_reg < CNT_MAX)) ? word_reg + CNT_W'(1) : word_reg;
        m_upd   = (hit && (match_reg < CNT_MAX)) ? match_reg + CNT_W'(1) : match_reg;
        if (hit)
        begin
            r_upd = (run_reg < CNT_MAX) ? run_reg + CNT_W'(1) : run_reg;
            b_upd = best_reg;
        end
        else
        begin
            r_upd = '0;
            b_upd = (run_reg > best_reg) ? run_reg : best_reg;
        end
        b_fin = (r_upd > b_upd) ? r_upd : b_upd;
        emit  = !s1_req_reg.has_window || s1_req_reg.end_of_pass;
        if (s1_req_reg.has_window)
        begin
            pass_tag = classify(b_fin, m_upd, w_upd, min_words_reg, switch_reg);
        end
        else
        begin
            pass_tag = TAG_UNCERTAIN;
        end
        h_base = s1_req_reg.new_read ? '0 : human_reg;
        u_base = s1_req_reg.new_read ? '0 : unc_reg;
        f_base = s1_req_reg.new_read ? '0 : foreign_reg;
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_req_next    = s1_req_reg;
        out_valid_next = out_valid_reg;
        out_rsp_next   = out_rsp_reg;
        word_next      = word_reg;
        match_next     = match_reg;
        run_next       = run_reg;
        best_next      = best_reg;
        human_next     = human_reg;
        unc_next       = unc_reg;
        foreign_next   = foreign_reg;
        read_tag       = TAG_UNCERTAIN;

        if (advance)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = s1_valid_reg && emit;
        end
        if (in_valid && !in_stall)
        begin
            s1_valid_next = 1'b1;
            s1_req_next   = in_req;
        end

        if (advance && s1_valid_reg)
        begin
            human_next   = h_base;
            unc_next     = u_base;
            foreign_next = f_base;
            if (emit)
            begin
                word_next  = '0;
                match_next = '0;
                run_next   = '0;
                best_next  = '0;
                case (pass_tag)
                    TAG_HUMAN:
                    begin
                        human_next = (h_base < VOTE_MAX) ? h_base + VOTE_W'(1) : h_base;
                    end
                    TAG_FOREIGN:
                    begin
                        foreign_next = (f_base < VOTE_MAX) ? f_base + VOTE_W'(1) : f_base;
                    end
                    default:
                    begin
                        unc_next = (u_base < VOTE_MAX) ? u_base + VOTE_W'(1) : u_base;
                    end
                endcase
                if (human_next != '0)
                begin
                    read_tag = TAG_HUMAN;
                end
                else if ((foreign_next != '0) && (unc_next == '0))
                begin
                    read_tag = TAG_FOREIGN;
                end
                else
                begin
                    read_tag = TAG_UNCERTAIN;
                end
                out_rsp_next.pass_tag = pass_tag;
                out_rsp_next.read_tag = read_tag;
                if (s1_req_reg.has_window)
                begin
                    out_rsp_next.word_total  = FIELD_W'(w_upd);
                    out_rsp_next.match_total = FIELD_W'(m_upd);
                    out_rsp_next.longest_run = FIELD_W'(b_fin);
                end
                else
                begin
                    out_rsp_next.word_total  = '0;
                    out_rsp_next.match_total = '0;
                    out_rsp_next.longest_run = '0;
                end
            end
            else
            begin
                word_next  = w_upd;
                match_next = m_upd;
                run_next   = r_upd;
                best_next  = b_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_amb_reg   <= MAX_AMB_RESET;
            min_words_reg <= MIN_WORDS_RESET;
            switch_reg    <= SWITCH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_AMBIGUITIES:   max_amb_reg   <= cfg_data[AMB_W-1:0];
                REG_MIN_WORDS:         min_words_reg <= cfg_data;
                REG_LONG_WORDS_SWITCH: switch_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            word_reg      <= '0;
            match_reg     <= '0;
            run_reg       <= '0;
            best_reg      <= '0;
            human_reg     <= '0;
            unc_reg       <= '0;
            foreign_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            word_reg      <= word_next;
            match_reg     <= match_next;
            run_reg       <= run_next;
            best_reg      <= best_next;
            human_reg     <= human_next;
            unc_reg       <= unc_next;
            foreign_reg   <= foreign_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_req_reg  <= s1_req_next;
        out_rsp_reg <= out_rsp_next;
    end

endmodule
`default_nettype wire
